// File: design/stable_priority_queue_unit_assert.svh
// Assertion macros for the queue RTL.
// Define NO_ASSERTIONS to compile the design without any checks.
`ifndef STABLE_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge outside of reset.
`define SPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SPQ_ASSERT(label, prop, msg)
`define SPQ_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// File: design/spq_pkg.sv
package spq_pkg;

    // Number of queue cells and the width of the fill count.
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Request commands.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Response status codes.
    localparam logic [1:0] ST_PUSHED = 2'd0;
    localparam logic [1:0] ST_POPPED = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic        command;
        logic [7:0]  priority_req;
        logic [15:0] message_handle;
    } spq_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] popped_handle;
        logic [7:0]  popped_priority;
        logic [4:0]  occupancy;
    } spq_rsp_t;

    // One stored entry.
    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] handle;
    } spq_entry_t;

    // Per-cell control from the queue controller.
    typedef struct packed {
        logic push_en;
        logic pop_en;
        logic occupied;
        logic ins_left;
    } spq_cell_ctl_t;

endpackage

// File: design/spq_cell.sv
module spq_cell
(
    input  logic                  clk,
    input  spq_pkg::spq_cell_ctl_t ctl,
    input  spq_pkg::spq_entry_t    new_entry,
    input  spq_pkg::spq_entry_t    left_entry,
    input  spq_pkg::spq_entry_t    right_entry,
    output spq_pkg::spq_entry_t    entry,
    output logic                  ins
);
    import spq_pkg::*;

    spq_entry_t entry_reg;
    spq_entry_t entry_next;

    // The new entry belongs at or before this cell when the cell is free or
    // holds a strictly lower priority, which keeps equal priorities in order.
    assign ins = !ctl.occupied || (entry_reg.prio < new_entry.prio);

    // A pop shifts toward the head; a push shifts behind the insertion point.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.pop_en)
        begin
            entry_next = right_entry;
        end
        else if (ctl.push_en)
        begin
            if (ctl.ins_left)
            begin
                entry_next = left_entry;
            end
            else if (ins)
            begin
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: design/stable_priority_queue_unit.sv
// Stable priority queue of spq_pkg::DEPTH entries held in a row of cells.
// Request channel (req, req_valid, req_stall): a push stores message_handle
// with priority_req behind every stored entry of greater or equal priority;
// a pop removes the head entry. Each request transfer yields one response.
// Response channel (rsp, rsp_valid, rsp_stall): status, the popped handle and
// priority (zero unless a pop succeeded) and the occupancy after the request.
// The response is valid in the cycle after the request transfer. Throughput
// is one request per cycle while rsp_stall is low; all cells compare against
// the new priority in parallel and shift in the same cycle, and the response
// register is the only stage.
// A push to a full queue returns the full status and changes nothing; a pop
// from an empty queue returns the empty status.
// Reset empties the queue and drops any pending response. While the receiver
// stalls, the response holds and req_stall is raised, so at most one
// response waits; a new request is taken in the cycle the response leaves.
module stable_priority_queue_unit
(
    input  logic             clk,
    input  logic             rst_n,
    input  spq_pkg::spq_req_t req,
    input  logic             req_valid,
    output logic             req_stall,
    output spq_pkg::spq_rsp_t rsp,
    output logic             rsp_valid,
    input  logic             rsp_stall
);
    import spq_pkg::*;

`include "stable_priority_queue_unit_assert.svh"

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    spq_rsp_t         rsp_reg;
    spq_rsp_t         rsp_next;

    logic             accept;
    logic             full;
    logic             empty;
    logic             push_ok;
    logic             pop_ok;
    spq_entry_t       new_entry;

    spq_entry_t       cell_entry [DEPTH];
    spq_cell_ctl_t    cell_ctl   [DEPTH];
    logic [DEPTH-1:0] cell_ins;

    // Handshake: a waiting response blocks a new transfer only while stalled.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = accept && (req.command == CMD_PUSH) && !full;
    assign pop_ok  = accept && (req.command == CMD_POP) && !empty;

    assign new_entry.prio   = req.priority_req;
    assign new_entry.handle = req.message_handle;

    // Row of cells; cell 0 is the head.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign cell_ctl[i].push_en  = push_ok;
        assign cell_ctl[i].pop_en   = pop_ok;
        assign cell_ctl[i].occupied = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign cell_ctl[i].ins_left = 1'b0;
        end
        else
        begin : g_body
            assign cell_ctl[i].ins_left = cell_ins[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            spq_cell u_cell
            (
                .clk         (clk),
                .ctl         (cell_ctl[i]),
                .new_entry   (new_entry),
                .left_entry  (cell_entry[(i == 0) ? 0 : i-1]),
                .right_entry (cell_entry[i]),
                .entry       (cell_entry[i]),
                .ins         (cell_ins[i])
            );
        end
        else
        begin : g_inner
            spq_cell u_cell
            (
                .clk         (clk),
                .ctl         (cell_ctl[i]),
                .new_entry   (new_entry),
                .left_entry  (cell_entry[(i == 0) ? 0 : i-1]),
                .right_entry (cell_entry[i+1]),
                .entry       (cell_entry[i]),
                .ins         (cell_ins[i])
            );
        end
    end

    // Fill count update.
    always_comb
    begin
        count_next = count_reg;
        if (push_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Response contents for the request in transfer.
    always_comb
    begin
        rsp_next                 = rsp_reg;
        rsp_next.popped_handle   = '0;
        rsp_next.popped_priority = '0;
        rsp_next.occupancy       = 5'(count_next);
        if (req.command == CMD_PUSH)
        begin
            rsp_next.status = full ? ST_FULL : ST_PUSHED;
        end
        else if (empty)
        begin
            rsp_next.status = ST_EMPTY;
        end
        else
        begin
            rsp_next.status          = ST_POPPED;
            rsp_next.popped_handle   = cell_entry[0].handle;
            rsp_next.popped_priority = cell_entry[0].prio;
        end
    end

    // Response valid: set by a transfer, cleared once the receiver takes it.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload loads only on a request transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    `SPQ_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "fill count above depth")
    `SPQ_ASSERT(a_push_count, push_ok |=> count_reg == $past(count_reg) + 1'b1, "push lost count")
    `SPQ_ASSERT(a_head_sorted, (count_reg >= CNT_W'(2)) |-> (cell_entry[0].prio >= cell_entry[1].prio), "head out of order")
    `SPQ_ASSERT(a_pop_head, pop_ok |=> rsp.popped_priority == $past(cell_entry[0].prio), "pop returned wrong entry")
    `SPQ_ASSERT(a_stall_held, req_stall |-> rsp_valid_reg, "stall without a waiting response")

endmodule

// File: tb/sv/stable_priority_queue_unit_tb.sv
module stable_priority_queue_unit_tb;

    import spq_pkg::*;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    spq_req_t req = '0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    spq_rsp_t rsp;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;

    // Commands waiting to be offered, and responses still owed by the block.
    spq_req_t cmd_backlog[$];
    spq_rsp_t awaited_rsp[$];

    // Shadow copy of the queue contents, head at index 0.
    logic [7:0]  model_prio[DEPTH];
    logic [15:0] model_handle[DEPTH];
    int          model_count = 0;

    int   error_count = 0;
    int   req_taken = 0;
    logic tail_phase = 1'b0;

    // Sender and receiver idling state.
    int gap_left = 0;
    int gap_rate = 0;
    int stall_left = 0;
    int stall_rate = 0;
    int hold_left = 0;
    bit pressure_done = 1'b0;

    stable_priority_queue_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Apply one command to the shadow queue and return the response it must produce.
    function automatic spq_rsp_t spq_apply(spq_req_t r);
        spq_rsp_t res;
        int       pos;
        res = '0;
        if (r.command == CMD_PUSH)
        begin
            if (model_count >= DEPTH)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                // The new entry goes behind every entry of greater or equal priority.
                pos = model_count;
                for (int i = model_count - 1; i >= 0; i--)
                    if (model_prio[i] < r.priority_req)
                        pos = i;
                for (int i = model_count; i > pos; i--)
                begin
                    model_prio[i]   = model_prio[i - 1];
                    model_handle[i] = model_handle[i - 1];
                end
                model_prio[pos]   = r.priority_req;
                model_handle[pos] = r.message_handle;
                model_count++;
                res.status = ST_PUSHED;
            end
        end
        else if (model_count == 0)
        begin
            res.status = ST_EMPTY;
        end
        else
        begin
            res.status          = ST_POPPED;
            res.popped_handle   = model_handle[0];
            res.popped_priority = model_prio[0];
            for (int i = 1; i < model_count; i++)
            begin
                model_prio[i - 1]   = model_prio[i];
                model_handle[i - 1] = model_handle[i];
            end
            model_count--;
        end
        res.occupancy = 5'(model_count);
        return res;
    endfunction

    task automatic queue_cmd(logic cmd, logic [7:0] p, logic [15:0] h);
        cmd_backlog.push_back('{command: cmd, priority_req: p, message_handle: h});
    endtask

    task automatic note_mismatch(string what, spq_rsp_t want, spq_rsp_t got);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s: expected status %0d handle %h prio %0d occ %0d, got status %0d handle %h prio %0d occ %0d",
                     $time, what, want.status, want.popped_handle, want.popped_priority,
                     want.occupancy, got.status, got.popped_handle, got.popped_priority,
                     got.occupancy);
    endtask

    // Request driver: holds a stalled transfer, otherwise inserts random gaps
    // or presents the next command from the backlog.
    always @(posedge clk or negedge rst_n)
    begin
        logic     nxt_valid;
        spq_req_t nxt_req;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            nxt_valid = req_valid;
            nxt_req   = req;
            if (req_valid && !req_stall)
            begin
                awaited_rsp.push_back(spq_apply(req));
                req_taken <= req_taken + 1;
                nxt_valid = 1'b0;
            end
            if ($urandom_range(0, 63) == 0)
                gap_rate = $urandom_range(0, 3);
            if (!nxt_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (!tail_phase && gap_rate != 0 && $urandom_range(1, 8) <= gap_rate)
                    gap_left = $urandom_range(0, 2);
                else if (cmd_backlog.size() > 0)
                begin
                    nxt_valid = 1'b1;
                    nxt_req   = cmd_backlog.pop_front();
                end
            end
            tail_phase <= (cmd_backlog.size() < 200);
            req_valid  <= nxt_valid;
            req        <= nxt_req;
        end
    end

    // Response stall: short random bursts, plus one long hold-off that lets
    // the block back up and stall its request side.
    always @(posedge clk or negedge rst_n)
    begin
        logic nxt_stall;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            nxt_stall = 1'b0;
            if (!pressure_done && req_taken >= 400)
            begin
                hold_left     = 80;
                pressure_done = 1'b1;
            end
            if ($urandom_range(0, 63) == 0)
                stall_rate = $urandom_range(0, 3);
            if (hold_left > 0)
            begin
                hold_left--;
                nxt_stall = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                nxt_stall = 1'b1;
            end
            else if (!tail_phase && stall_rate != 0 && $urandom_range(1, 8) <= stall_rate)
            begin
                stall_left = $urandom_range(0, 2);
                nxt_stall  = 1'b1;
            end
            rsp_stall <= nxt_stall;
        end
    end

    // Response monitor: every transfer is checked against the oldest expectation.
    always @(posedge clk)
    begin
        spq_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_rsp.size() == 0)
                note_mismatch("response with none expected", '0, rsp);
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp.status !== want.status || rsp.popped_handle !== want.popped_handle ||
                    rsp.popped_priority !== want.popped_priority ||
                    rsp.occupancy !== want.occupancy)
                    note_mismatch("response mismatch", want, rsp);
            end
        end
    end

    initial
    begin
        int gen_fill;
        int made;
        int seg_left;
        int push_pct;
        logic cmd;
        logic [7:0] p;
        for (int i = 0; i < DEPTH; i++)
        begin
            model_prio[i]   = '0;
            model_handle[i] = '0;
        end

        // Directed part: pop on empty, extreme values, ties at the top, middle
        // and bottom, filling to full, a push on full, then draining some.
        queue_cmd(CMD_POP, 8'd0, 16'h0000);
        queue_cmd(CMD_PUSH, 8'd255, 16'hFFFF);
        queue_cmd(CMD_PUSH, 8'd0, 16'h0000);
        queue_cmd(CMD_PUSH, 8'd128, 16'h1234);
        queue_cmd(CMD_PUSH, 8'd128, 16'h1235);
        queue_cmd(CMD_PUSH, 8'd128, 16'h1236);
        queue_cmd(CMD_PUSH, 8'd0, 16'h0001);
        queue_cmd(CMD_PUSH, 8'd255, 16'h0002);
        for (int i = 0; i < DEPTH - 7; i++)
            queue_cmd(CMD_PUSH, (i % 3 == 0) ? 8'd255 : (i % 3 == 1) ? 8'd128 : 8'd1,
                      16'(16'hA000 + i));
        queue_cmd(CMD_PUSH, 8'd255, 16'hABCD);
        for (int i = 0; i < 7; i++)
            queue_cmd(CMD_POP, 8'hFF, 16'hFFFF);
        gen_fill = DEPTH - 7;

        // Random part: segments that lean toward pushes or pops so the fill
        // level sweeps from empty to full, with many priority ties.
        made = 0;
        seg_left = 0;
        push_pct = 50;
        while (made < 1850)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(10, 60);
                case ($urandom_range(0, 2))
                    0: push_pct = 15;
                    1: push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            seg_left--;
            cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
            case ($urandom_range(0, 5))
                0, 1: p = 8'($urandom_range(0, 3));
                2, 3: p = 8'($urandom_range(0, 255));
                4: p = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                default: p = 8'($urandom_range(127, 129));
            endcase
            queue_cmd(cmd, p, 16'($urandom));
            if (cmd == CMD_PUSH && gen_fill < DEPTH)
                gen_fill++;
            else if (cmd == CMD_POP && gen_fill > 0)
                gen_fill--;
            made++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all commands transferred and every response seen.
        while (cmd_backlog.size() != 0 || req_valid || awaited_rsp.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
        if (awaited_rsp.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("stable_priority_queue_unit_tb OK");
        else
            $display("stable_priority_queue_unit_tb NOT OK");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("stable_priority_queue_unit_tb NOT OK");
        $finish;
    end

endmodule

// File: stable_priority_queue_unit.f
+incdir+design
design/spq_pkg.sv
design/spq_cell.sv
design/stable_priority_queue_unit.sv
tb/sv/stable_priority_queue_unit_tb.sv
